// ----- hw/rtl/rv32dec_pkg.sv -----
// ----------------------------------------------------------------------------
// RV32I decoder package
// Operation codes, opcode values and field types shared by the decoder.
// ----------------------------------------------------------------------------
package rv32dec_pkg;

  typedef logic [5:0]  op_t;
  typedef logic [6:0]  opcode_t;
  typedef logic [4:0]  reg_idx_t;
  typedef logic [31:0] word_t;

  // Major opcodes
  localparam opcode_t OPC_LUI    = 7'h37;
  localparam opcode_t OPC_AUIPC  = 7'h17;
  localparam opcode_t OPC_JAL    = 7'h6f;
  localparam opcode_t OPC_JALR   = 7'h67;
  localparam opcode_t OPC_BRANCH = 7'h63;
  localparam opcode_t OPC_LOAD   = 7'h03;
  localparam opcode_t OPC_STORE  = 7'h23;
  localparam opcode_t OPC_OP_IMM = 7'h13;
  localparam opcode_t OPC_OP     = 7'h33;
  localparam opcode_t OPC_SYSTEM = 7'h73;

  localparam word_t WORD_ECALL  = 32'h0000_0073;
  localparam word_t WORD_EBREAK = 32'h0010_0073;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // Operation codes
  localparam op_t OP_ILLEGAL = 6'd0;
  localparam op_t OP_LUI     = 6'd1;
  localparam op_t OP_AUIPC   = 6'd2;
  localparam op_t OP_JAL     = 6'd3;
  localparam op_t OP_JALR    = 6'd4;
  localparam op_t OP_BEQ     = 6'd5;
  localparam op_t OP_BNE     = 6'd6;
  localparam op_t OP_BLT     = 6'd7;
  localparam op_t OP_BGE     = 6'd8;
  localparam op_t OP_BLTU    = 6'd9;
  localparam op_t OP_BGEU    = 6'd10;
  localparam op_t OP_LB      = 6'd11;
  localparam op_t OP_LH      = 6'd12;
  localparam op_t OP_LW      = 6'd13;
  localparam op_t OP_LBU     = 6'd14;
  localparam op_t OP_LHU     = 6'd15;
  localparam op_t OP_SB      = 6'd16;
  localparam op_t OP_SH      = 6'd17;
  localparam op_t OP_SW      = 6'd18;
  localparam op_t OP_ADDI    = 6'd19;
  localparam op_t OP_SLTI    = 6'd20;
  localparam op_t OP_SLTIU   = 6'd21;
  localparam op_t OP_XORI    = 6'd22;
  localparam op_t OP_ORI     = 6'd23;
  localparam op_t OP_ANDI    = 6'd24;
  localparam op_t OP_SLLI    = 6'd25;
  localparam op_t OP_SRLI    = 6'd26;
  localparam op_t OP_SRAI    = 6'd27;
  localparam op_t OP_ADD     = 6'd28;
  localparam op_t OP_SUB     = 6'd29;
  localparam op_t OP_SLL     = 6'd30;
  localparam op_t OP_SLT     = 6'd31;
  localparam op_t OP_SLTU    = 6'd32;
  localparam op_t OP_XOR     = 6'd33;
  localparam op_t OP_SRL     = 6'd34;
  localparam op_t OP_SRA     = 6'd35;
  localparam op_t OP_OR      = 6'd36;
  localparam op_t OP_AND     = 6'd37;
  localparam op_t OP_CSRRW   = 6'd38;
  localparam op_t OP_CSRRS   = 6'd39;
  localparam op_t OP_CSRRC   = 6'd40;
  localparam op_t OP_CSRRWI  = 6'd41;
  localparam op_t OP_CSRRSI  = 6'd42;
  localparam op_t OP_CSRRCI  = 6'd43;
  localparam op_t OP_ECALL   = 6'd44;
  localparam op_t OP_EBREAK  = 6'd45;

endpackage

// ----- hw/rtl/rv32i_instruction_decoder_top.sv -----
// ----------------------------------------------------------------------------
// RV32I instruction decoder
// Classifies one instruction word per item and returns register fields,
// format immediate and jal/branch target.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries the instruction word and its
//   address. Output channel out_valid/out_ready carries the decoded operation
//   (0 = illegal), rd/rs1/rs2, the immediate (zero-extended for shifts
//   and CSRs, else sign-extended) and the target. The input register
//   holds the word; the decode and target adder feed the result register.
//   Throughput is one item per cycle while results are taken; the two
//   register stages advance whenever the result register is empty or being
//   taken, so a new item is taken while a result waits if stage 1 is empty.
//   When the receiver stalls, the pipe fills (two items held) and in_ready
//   drops; no item is lost or repeated. The critical path is the 32-bit
//   target adder behind the immediate select.
//   Reset clears both stage valid flags; payload registers are not reset.
//   Illegal words (including fence) give all-zero result fields.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rv32dec_pkg::word_t  in_pc_address,
  input  rv32dec_pkg::word_t  in_instruction,
  output logic                out_valid,
  input  logic                out_ready,
  output rv32dec_pkg::op_t    out_operation,
  output rv32dec_pkg::reg_idx_t out_dest_reg,
  output rv32dec_pkg::reg_idx_t out_src_reg_one,
  output rv32dec_pkg::reg_idx_t out_src_reg_two,
  output logic signed [31:0]  out_immediate,
  output rv32dec_pkg::word_t  out_target
);
  import rv32dec_pkg::*;

  // stage 1: input register
  logic     s1_valid_r;
  word_t    s1_pc_r;
  word_t    s1_instr_r;

  // stage 2: result register
  logic     out_valid_r;
  op_t      op_r,  op_nxt;
  reg_idx_t rd_r,  rd_nxt;
  reg_idx_t rs1_r, rs1_nxt;
  reg_idx_t rs2_r, rs2_nxt;
  word_t    imm_r, imm_nxt;
  word_t    tgt_r, tgt_nxt;

  logic out_adv;
  assign out_adv  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_pc_r    <= in_pc_address;
      s1_instr_r <= in_instruction;
    end
  end

  // decode
  word_t      w;
  opcode_t    opc;
  logic [2:0] f3;
  logic [6:0] f7;
  word_t      imm_i, imm_s, imm_b, imm_j, imm_u, imm_sh, imm_csr;
  logic       has_tgt;

  always_comb begin
    w       = s1_instr_r;
    opc     = w[6:0];
    f3      = w[14:12];
    f7      = w[31:25];
    imm_i   = {{20{w[31]}}, w[31:20]};
    imm_s   = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b   = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j   = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    imm_u   = {w[31:12], 12'h000};
    imm_sh  = {27'd0, w[24:20]};
    imm_csr = {20'd0, w[31:20]};

    op_nxt  = OP_ILLEGAL;
    imm_nxt = '0;
    has_tgt = 1'b0;

    if (w == WORD_ECALL) begin
      op_nxt = OP_ECALL;
    end else if (w == WORD_EBREAK) begin
      op_nxt = OP_EBREAK;
    end else begin
      case (opc)
        OPC_LUI: begin
          op_nxt  = OP_LUI;
          imm_nxt = imm_u;
        end
        OPC_AUIPC: begin
          op_nxt  = OP_AUIPC;
          imm_nxt = imm_u;
        end
        OPC_JAL: begin
          op_nxt  = OP_JAL;
          imm_nxt = imm_j;
          has_tgt = 1'b1;
        end
        OPC_JALR: begin
          if (f3 == 3'd0) begin
            op_nxt  = OP_JALR;
            imm_nxt = imm_i;
          end
        end
        OPC_BRANCH: begin
          if (!(f3 inside {3'd2, 3'd3})) begin
            case (f3)
              3'd0:    op_nxt = OP_BEQ;
              3'd1:    op_nxt = OP_BNE;
              3'd4:    op_nxt = OP_BLT;
              3'd5:    op_nxt = OP_BGE;
              3'd6:    op_nxt = OP_BLTU;
              default: op_nxt = OP_BGEU;
            endcase
            imm_nxt = imm_b;
            has_tgt = 1'b1;
          end
        end
        OPC_LOAD: begin
          case (f3)
            3'd0:    op_nxt = OP_LB;
            3'd1:    op_nxt = OP_LH;
            3'd2:    op_nxt = OP_LW;
            3'd4:    op_nxt = OP_LBU;
            3'd5:    op_nxt = OP_LHU;
            default: op_nxt = OP_ILLEGAL;
          endcase
          if (op_nxt != OP_ILLEGAL) imm_nxt = imm_i;
        end
        OPC_STORE: begin
          case (f3)
            3'd0:    op_nxt = OP_SB;
            3'd1:    op_nxt = OP_SH;
            3'd2:    op_nxt = OP_SW;
            default: op_nxt = OP_ILLEGAL;
          endcase
          if (op_nxt != OP_ILLEGAL) imm_nxt = imm_s;
        end
        OPC_OP_IMM: begin
          case (f3)
            3'd0:    op_nxt = OP_ADDI;
            3'd2:    op_nxt = OP_SLTI;
            3'd3:    op_nxt = OP_SLTIU;
            3'd4:    op_nxt = OP_XORI;
            3'd6:    op_nxt = OP_ORI;
            3'd7:    op_nxt = OP_ANDI;
            3'd1:    op_nxt = (f7 == F7_BASE) ? OP_SLLI : OP_ILLEGAL;
            default: op_nxt = (f7 == F7_BASE) ? OP_SRLI :
                              (f7 == F7_ALT)  ? OP_SRAI : OP_ILLEGAL;
          endcase
          // shifts carry the shift amount, not the I immediate
          if (f3 inside {3'd1, 3'd5}) begin
            if (op_nxt != OP_ILLEGAL) imm_nxt = imm_sh;
          end else begin
            imm_nxt = imm_i;
          end
        end
        OPC_OP: begin
          if (f7 == F7_BASE) begin
            case (f3)
              3'd0:    op_nxt = OP_ADD;
              3'd1:    op_nxt = OP_SLL;
              3'd2:    op_nxt = OP_SLT;
              3'd3:    op_nxt = OP_SLTU;
              3'd4:    op_nxt = OP_XOR;
              3'd5:    op_nxt = OP_SRL;
              3'd6:    op_nxt = OP_OR;
              default: op_nxt = OP_AND;
            endcase
          end else if (f7 == F7_ALT && f3 == 3'd0) begin
            op_nxt = OP_SUB;
          end else if (f7 == F7_ALT && f3 == 3'd5) begin
            op_nxt = OP_SRA;
          end
        end
        OPC_SYSTEM: begin
          case (f3)
            3'd1:    op_nxt = OP_CSRRW;
            3'd2:    op_nxt = OP_CSRRS;
            3'd3:    op_nxt = OP_CSRRC;
            3'd5:    op_nxt = OP_CSRRWI;
            3'd6:    op_nxt = OP_CSRRSI;
            3'd7:    op_nxt = OP_CSRRCI;
            default: op_nxt = OP_ILLEGAL;
          endcase
          if (op_nxt != OP_ILLEGAL) imm_nxt = imm_csr;
        end
        default: op_nxt = OP_ILLEGAL;
      endcase
    end

    if (op_nxt != OP_ILLEGAL) begin
      rd_nxt  = w[11:7];
      rs1_nxt = w[19:15];
      rs2_nxt = w[24:20];
    end else begin
      rd_nxt  = '0;
      rs1_nxt = '0;
      rs2_nxt = '0;
    end

    tgt_nxt = has_tgt ? (s1_pc_r + imm_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
    if (out_adv && s1_valid_r) begin
      op_r  <= op_nxt;
      rd_r  <= rd_nxt;
      rs1_r <= rs1_nxt;
      rs2_r <= rs2_nxt;
      imm_r <= imm_nxt;
      tgt_r <= tgt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_operation   = op_r;
  assign out_dest_reg    = rd_r;
  assign out_src_reg_one = rs1_r;
  assign out_src_reg_two = rs2_r;
  assign out_immediate   = imm_r;
  assign out_target      = tgt_r;

endmodule
